// ----- rtl/rsi_pkg.sv -----
// rsi_pkg: shared types, widths and helpers for the ray/sphere intersection pipeline.
// No dependencies; imported by ray_sphere_intersect.
package rsi_pkg;

    localparam int CW       = 32;               // coordinate width, Q.16
    localparam int DW       = 16;               // direction width
    localparam int DFB      = 14;               // direction fraction bits
    localparam int RAD_W    = CW - 1;
    localparam int L_W      = CW + 1;           // center - origin
    localparam int PD_W     = L_W + DW;         // l * dir
    localparam int TCA_W    = PD_W + 2;         // sum of three products
    localparam int TCAR_W   = TCA_W + 1;        // tca plus rounding half
    localparam int LO_W     = (TCA_W + 1) / 2;  // low split of |tca|
    localparam int HI_W     = TCA_W - LO_W;
    localparam int TCA2_W   = 2 * TCA_W;
    localparam int LSQ_W    = 2 * L_W;
    localparam int L2_W     = LSQ_W + 2;
    localparam int RSQ_W    = 2 * RAD_W;
    localparam int L2MR_W   = L2_W + 1;
    localparam int BOUND_W  = L2MR_W + 2 * DFB;
    localparam int DIFF_W   = TCA2_W + 1;
    localparam int DISC_W   = TCA2_W;
    localparam int ROOT_W   = DISC_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int SUM_W    = TCAR_W + 1;
    localparam int SH_W     = SUM_W - DFB;
    localparam int LATENCY  = ROOT_W + 7;
    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(65536);

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [DW-1:0] dir_x;
        logic signed [DW-1:0] dir_y;
        logic signed [DW-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] t_near;
        logic signed [CW-1:0] t_far;
    } result_t;

    // clamp a shifted distance to the signed coordinate range
    function automatic logic [CW-1:0] sat_coord(input logic [SH_W-1:0] v);
        logic [CW-1:0] r;
        if (!v[SH_W-1] && (|v[SH_W-2:CW-1]))
            r = {1'b0, {(CW-1){1'b1}}};
        else if (v[SH_W-1] && !(&v[SH_W-2:CW-1]))
            r = {1'b1, {(CW-1){1'b0}}};
        else
            r = v[CW-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/ray_sphere_intersect.sv -----
// ray_sphere_intersect: fully pipelined geometric ray/sphere test with a
// one-bit-per-stage square root. Depends on rsi_pkg.
//
// Usage:
//   Sphere: write center_x/y/z and radius on the cfg channel (cfg_valid,
//   cfg_ready, cfg_index, cfg_data); cfg_ready is always high. Write only
//   while no ray is in flight.
//   Rays: drive ray and pulse start; busy stays low, so a ray is taken
//   every cycle.
//   Results: done is high for one cycle with result; each beat follows
//   its start beat through every pipeline stage, in order, one per ray.
//   Throughput is one ray per cycle. The pipeline holds 5 arithmetic
//   stages and the hit-test stage, then the square root in 51 stages,
//   one root bit each, then one rounding/saturation output stage.
//   The receiver cannot stall; no result is held back.
//   Reset clears all valid bits and loads center = 0, radius = 1.0.
//   A miss returns hit = 0 with both distances zero.
module ray_sphere_intersect
    import rsi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ray_t                ray,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CW-1:0]       cfg_data,
    output logic                done,
    output result_t             result
);

    logic signed [CW-1:0]    cx_reg, cy_reg, cz_reg;
    logic [RAD_W-1:0]        rad_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X: cx_reg  <= cfg_data;
                REG_CENTER_Y: cy_reg  <= cfg_data;
                REG_CENTER_Z: cz_reg  <= cfg_data;
                REG_RADIUS:   rad_reg <= cfg_data[RAD_W-1:0];
            endcase
        end
    end

    // valid bits
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic sq_vld_reg [0:ROOT_W];
    logic done_reg;

    // stage 1: l = center - origin
    logic signed [L_W-1:0]  s1_lx_reg, s1_ly_reg, s1_lz_reg;
    logic signed [DW-1:0]   s1_dx_reg, s1_dy_reg, s1_dz_reg;

    always_ff @(posedge clk)
    begin
        s1_lx_reg <= L_W'(cx_reg) - L_W'(ray.origin_x);
        s1_ly_reg <= L_W'(cy_reg) - L_W'(ray.origin_y);
        s1_lz_reg <= L_W'(cz_reg) - L_W'(ray.origin_z);
        s1_dx_reg <= ray.dir_x;
        s1_dy_reg <= ray.dir_y;
        s1_dz_reg <= ray.dir_z;
    end

    // stage 2: products
    logic signed [PD_W-1:0]  px, py, pz;
    logic signed [LSQ_W-1:0] qx, qy, qz;
    logic [RSQ_W-1:0]        rsq;
    logic signed [PD_W-1:0]  s2_px_reg, s2_py_reg, s2_pz_reg;
    logic [LSQ_W-1:0]        s2_qx_reg, s2_qy_reg, s2_qz_reg;
    logic [RSQ_W-1:0]        s2_rsq_reg;

    assign px  = s1_lx_reg * s1_dx_reg;
    assign py  = s1_ly_reg * s1_dy_reg;
    assign pz  = s1_lz_reg * s1_dz_reg;
    assign qx  = s1_lx_reg * s1_lx_reg;
    assign qy  = s1_ly_reg * s1_ly_reg;
    assign qz  = s1_lz_reg * s1_lz_reg;
    assign rsq = rad_reg * rad_reg;

    always_ff @(posedge clk)
    begin
        s2_px_reg  <= px;
        s2_py_reg  <= py;
        s2_pz_reg  <= pz;
        s2_qx_reg  <= qx;
        s2_qy_reg  <= qy;
        s2_qz_reg  <= qz;
        s2_rsq_reg <= rsq;
    end

    // stage 3: tca and l^2 - r^2
    logic signed [TCA_W-1:0]  s3_tca_reg;
    logic signed [L2MR_W-1:0] s3_l2mr_reg;

    always_ff @(posedge clk)
    begin
        s3_tca_reg  <= TCA_W'(s2_px_reg) + TCA_W'(s2_py_reg) + TCA_W'(s2_pz_reg);
        s3_l2mr_reg <= L2MR_W'(s2_qx_reg) + L2MR_W'(s2_qy_reg) + L2MR_W'(s2_qz_reg)
                       - L2MR_W'(s2_rsq_reg);
    end

    // stage 4: split square of |tca|
    logic [TCA_W-1:0]         tca_abs;
    logic [HI_W-1:0]          tca_hi;
    logic [LO_W-1:0]          tca_lo;
    logic [2*HI_W-1:0]        pp_hh;
    logic [HI_W+LO_W-1:0]     pp_hl;
    logic [2*LO_W-1:0]        pp_ll;
    logic [2*HI_W-1:0]        s4_hh_reg;
    logic [HI_W+LO_W-1:0]     s4_hl_reg;
    logic [2*LO_W-1:0]        s4_ll_reg;
    logic signed [TCAR_W-1:0] s4_tcar_reg, s5_tcar_reg;
    logic signed [BOUND_W-1:0] s4_bound_reg, s5_bound_reg;

    assign tca_abs = s3_tca_reg[TCA_W-1] ? TCA_W'(-s3_tca_reg) : TCA_W'(s3_tca_reg);
    assign tca_hi  = tca_abs[TCA_W-1:LO_W];
    assign tca_lo  = tca_abs[LO_W-1:0];
    assign pp_hh   = tca_hi * tca_hi;
    assign pp_hl   = tca_hi * tca_lo;
    assign pp_ll   = tca_lo * tca_lo;

    always_ff @(posedge clk)
    begin
        s4_hh_reg    <= pp_hh;
        s4_hl_reg    <= pp_hl;
        s4_ll_reg    <= pp_ll;
        s4_tcar_reg  <= TCAR_W'(s3_tca_reg) + TCAR_W'(1 << (DFB - 1));
        s4_bound_reg <= {s3_l2mr_reg, {(2 * DFB){1'b0}}};
    end

    // stage 5: tca^2
    logic [TCA2_W-1:0] s5_tca2_reg;

    always_ff @(posedge clk)
    begin
        s5_tca2_reg  <= (TCA2_W'(s4_hh_reg) << (2 * LO_W))
                        + (TCA2_W'(s4_hl_reg) << (LO_W + 1))
                        + TCA2_W'(s4_ll_reg);
        s5_tcar_reg  <= s4_tcar_reg;
        s5_bound_reg <= s4_bound_reg;
    end

    // hit test and square root feed
    logic [DIFF_W-1:0]        diff;
    logic [DISC_W-1:0]        sq_d_reg    [0:ROOT_W];
    logic [REM_W-1:0]         sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]        sq_root_reg [0:ROOT_W];
    logic signed [TCAR_W-1:0] sq_tcar_reg [0:ROOT_W];
    logic                     sq_hit_reg  [0:ROOT_W];

    assign diff = DIFF_W'(s5_tca2_reg) - DIFF_W'(s5_bound_reg);

    always_ff @(posedge clk)
    begin
        sq_d_reg[0]    <= diff[DISC_W-1:0];
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        sq_tcar_reg[0] <= s5_tcar_reg;
        sq_hit_reg[0]  <= !diff[DIFF_W-1];
    end

    // one root bit per stage
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        logic [REM_W-1:0] rem_sh, trial;
        logic             take;

        always_comb
        begin
            rem_sh = {sq_rem_reg[k][REM_W-3:0], sq_d_reg[k][DISC_W-1 -: 2]};
            trial  = REM_W'({sq_root_reg[k], 2'b01});
            take   = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k+1] <= 1'b0;
            else
                sq_vld_reg[k+1] <= sq_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            sq_d_reg[k+1]    <= {sq_d_reg[k][DISC_W-3:0], 2'b00};
            sq_rem_reg[k+1]  <= take ? (rem_sh - trial) : rem_sh;
            sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], take};
            sq_tcar_reg[k+1] <= sq_tcar_reg[k];
            sq_hit_reg[k+1]  <= sq_hit_reg[k];
        end
    end

    // output stage: round, saturate
    logic [ROOT_W-1:0]       thc;
    logic signed [SUM_W-1:0] near_sum, far_sum;
    logic signed [SH_W-1:0]  near_q, far_q;
    result_t                 result_next, result_reg;

    assign thc      = sq_root_reg[ROOT_W];
    assign near_sum = SUM_W'(sq_tcar_reg[ROOT_W]) - SUM_W'(thc);
    assign far_sum  = SUM_W'(sq_tcar_reg[ROOT_W]) + SUM_W'(thc);
    assign near_q   = SH_W'(near_sum >>> DFB);
    assign far_q    = SH_W'(far_sum >>> DFB);

    always_comb
    begin
        result_next.hit = sq_hit_reg[ROOT_W];
        if (sq_hit_reg[ROOT_W])
        begin
            result_next.t_near = sat_coord(near_q);
            result_next.t_far  = sat_coord(far_q);
        end
        else
        begin
            result_next.t_near = '0;
            result_next.t_far  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            sq_vld_reg[0] <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_vld_reg    <= start && !busy;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            sq_vld_reg[0] <= s5_vld_reg;
            done_reg      <= sq_vld_reg[ROOT_W];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("ray result missing at pipeline latency");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without a matching ray");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.t_near == '0 && result.t_far == '0))
        else $error("miss with nonzero distance");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit) |-> (result.t_near <= result.t_far))
        else $error("near distance beyond far distance");

endmodule

// ----- bench/tb_ray_sphere_intersect.sv -----
// Testbench for ray_sphere_intersect: random and directed rays against several sphere
// settings, checked against a wide-integer predictor. Depends on rsi_pkg and the RTL.
`timescale 1ns / 100ps

module tb_ray_sphere_intersect;
    import rsi_pkg::*;

    typedef logic signed [255:0] wide_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    ray_t          ray;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_index;
    logic [CW-1:0] cfg_data;
    logic          done;
    result_t       result;

    ray_t    ray_queue[$];
    result_t hits_expected[$];
    int      errors;
    int      idle_left;
    bit      quiet;
    longint  cycles;

    logic signed [CW-1:0] ctr_x, ctr_y, ctr_z;
    logic [RAD_W-1:0]     rad;

    ray_sphere_intersect DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .ray(ray),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [CW-1:0] round_sat(wide_t t);
        wide_t v;
        v = (t + (wide_t'(1) <<< (DFB - 1))) >>> DFB;
        if (v > wide_t'(32'sh7fffffff))
            return 32'sh7fffffff;
        if (v < -(wide_t'(1) <<< 31))
            return 32'sh80000000;
        return v[CW-1:0];
    endfunction

    function automatic result_t predict_sphere_hit(ray_t r);
        wide_t   lx, ly, lz, tca, l2, rw, bound, disc, root, cand;
        result_t res;
        lx = wide_t'($signed(ctr_x)) - wide_t'($signed(r.origin_x));
        ly = wide_t'($signed(ctr_y)) - wide_t'($signed(r.origin_y));
        lz = wide_t'($signed(ctr_z)) - wide_t'($signed(r.origin_z));
        tca = lx * wide_t'($signed(r.dir_x)) + ly * wide_t'($signed(r.dir_y))
            + lz * wide_t'($signed(r.dir_z));
        l2 = lx * lx + ly * ly + lz * lz;
        rw = wide_t'({1'b0, rad});
        bound = (l2 - rw * rw) <<< (2 * DFB);
        res = '0;
        if (tca * tca < bound)
            return res;
        disc = tca * tca - bound;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (wide_t'(1) <<< b);
            if (cand * cand <= disc)
                root = cand;
        end
        res.hit = 1'b1;
        res.t_near = round_sat(tca - root);
        res.t_far = round_sat(tca + root);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            ray <= '0;
            idle_left = 0;
        end
        else
        begin
            if (start && !busy)
                hits_expected.push_back(predict_sphere_hit(ray));
            if (!(start && busy))
            begin
                if (idle_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                    idle_left = $urandom_range(1, 4);
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (ray_queue.size() > 0)
                begin
                    start <= 1'b1;
                    ray <= ray_queue.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (hits_expected.size() == 0)
            begin
                $display("unexpected result beat at %0t", $realtime);
                errors++;
            end
            else
            begin
                result_t want;
                want = hits_expected.pop_front();
                if (result.hit !== want.hit)
                    report_mismatch("hit", CW'(result.hit), CW'(want.hit));
                if (result.t_near !== want.t_near)
                    report_mismatch("t_near", result.t_near, want.t_near);
                if (result.t_far !== want.t_far)
                    report_mismatch("t_far", result.t_far, want.t_far);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CENTER_X: ctr_x = val;
            REG_CENTER_Y: ctr_y = val;
            REG_CENTER_Z: ctr_z = val;
            REG_RADIUS:   rad = val[RAD_W-1:0];
        endcase
    endtask

    task automatic set_sphere(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                              logic [CW-1:0] r);
        write_reg(REG_CENTER_X, x);
        write_reg(REG_CENTER_Y, y);
        write_reg(REG_CENTER_Z, z);
        write_reg(REG_RADIUS, r);
    endtask

    task automatic drain();
        do @(posedge clk);
        while (ray_queue.size() > 0 || start || hits_expected.size() > 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic ray_t make_ray(logic signed [CW-1:0] ox, logic signed [CW-1:0] oy,
                                      logic signed [CW-1:0] oz, logic signed [DW-1:0] dx,
                                      logic signed [DW-1:0] dy, logic signed [DW-1:0] dz);
        ray_t r;
        r.origin_x = ox;
        r.origin_y = oy;
        r.origin_z = oz;
        r.dir_x = dx;
        r.dir_y = dy;
        r.dir_z = dz;
        return r;
    endfunction

    // mostly rays aimed near the sphere, some fully random
    task automatic queue_random(int n, int spread);
        ray_t r;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                r = make_ray(CW'($urandom), CW'($urandom), CW'($urandom),
                             DW'($urandom), DW'($urandom), DW'($urandom));
            else
            begin
                r.origin_x = ctr_x + $signed(CW'($urandom_range(0, 2 * spread))) - spread;
                r.origin_y = ctr_y + $signed(CW'($urandom_range(0, 2 * spread))) - spread;
                r.origin_z = ctr_z + $signed(CW'($urandom_range(0, 2 * spread))) - spread;
                case ($urandom_range(0, 2))
                    0: begin
                        r.dir_x = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                        r.dir_y = '0;
                        r.dir_z = '0;
                    end
                    1: begin
                        r.dir_x = $signed(DW'($urandom_range(0, 18918))) - 16'sd9459;
                        r.dir_y = $signed(DW'($urandom_range(0, 18918))) - 16'sd9459;
                        r.dir_z = $signed(DW'($urandom_range(0, 18918))) - 16'sd9459;
                    end
                    default: begin
                        r.dir_x = DW'($urandom);
                        r.dir_y = DW'($urandom);
                        r.dir_z = DW'($urandom);
                    end
                endcase
            end
            ray_queue.push_back(r);
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data = '0;
        ctr_x = '0;
        ctr_y = '0;
        ctr_z = '0;
        rad = RADIUS_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sphere: unit sphere at origin
        ray_queue.push_back(make_ray(-32'sd327680, 32'sd65536, 0, 16'sd16384, 0, 0));
        ray_queue.push_back(make_ray(-32'sd327680, 0, 0, 16'sd16384, 0, 0));
        ray_queue.push_back(make_ray(32'sd327680, 0, 0, 16'sd16384, 0, 0));
        ray_queue.push_back(make_ray(0, 0, 0, 0, 16'sd16384, 0));
        ray_queue.push_back(make_ray(0, 32'sd131072, 0, 0, 0, 16'sd16384));
        ray_queue.push_back(make_ray(0, 0, -32'sd196608, 16'sd8192, 16'sd8192, 16'sd8192));
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0));
        ray_queue.push_back(make_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                     16'sh7fff, 16'sh7fff, 16'sh7fff));
        ray_queue.push_back(make_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                     16'sh8000, 16'sh8000, 16'sh8000));
        ray_queue.push_back(make_ray(32'sh80000000, 0, 0, 16'sh7fff, 0, 0));
        ray_queue.push_back(make_ray(32'sh7fffffff, 0, 0, 16'sh8000, 0, 0));
        queue_random(80, 1 << 18);
        drain();

        // extreme center, largest radius; radius write carries a stray top bit
        set_sphere(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        ray_queue.push_back(make_ray(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                     16'sh7fff, 16'sh8000, 16'sh7fff));
        ray_queue.push_back(make_ray(0, 0, 0, 16'sh8000, 16'sh7fff, 16'sh8000));
        ray_queue.push_back(make_ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0));
        queue_random(150, 32'h7fffffff);
        drain();

        // zero radius
        set_sphere(32'h00030000, 32'hfffd0000, 32'h0, 32'h0);
        ray_queue.push_back(make_ray(0, 32'shfffd0000, 0, 16'sd16384, 0, 0));
        ray_queue.push_back(make_ray(0, 0, 0, 16'sd16384, 0, 0));
        queue_random(120, 1 << 16);
        drain();

        set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 32'h40000000);
        queue_random(150, 1 << 30);
        drain();

        repeat (2)
        begin
            set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 1 << 24));
            queue_random(100, 1 << 24);
            drain();
        end

        quiet = 1'b1;
        set_sphere($urandom_range(0, 1 << 20), $urandom, $urandom_range(0, 1 << 20),
                   $urandom_range(1 << 16, 1 << 22));
        queue_random(100, 1 << 22);
        drain();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
